@@ rtl/bpa_pkg.sv @@
// Shared types, constants and a helper function of the page frame allocator.
package bpa_pkg;

  localparam int PAGE_W   = 17;
  localparam int FREE_W   = 18;
  localparam int REF_W    = 8;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;

  localparam int DEF_MAX_PAGES = 131072;
  localparam int DEF_REF_MAX   = 255;

  localparam int WORD_W   = 64;
  localparam int WORD_SH  = 6;
  localparam int SUM_SH   = 2 * WORD_SH;
  localparam int RC_LANES = 8;
  localparam int RC_SH    = 3;

  localparam logic [FREE_W-1:0] ACTIVE_RESET = FREE_W'(131072);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 3'd0,
    OP_FREE    = 3'd1,
    OP_REF     = 3'd2,
    OP_UNREF   = 3'd3,
    OP_QUERY   = 3'd4,
    OP_RELEASE = 3'd5,
    OP_RESERVE = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_OOM      = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOCHANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    K_ALLOC,
    K_PAGE,
    K_RANGE,
    K_IGNORE
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    op_t               op;
    logic [PAGE_W-1:0] page;
  } bpa_entry_t;

  typedef enum logic [2:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_ALLOC_L1,
    BS_ALLOC_L0,
    BS_MODIFY,
    BS_SUMMARY
  } back_state_t;

  function automatic logic [WORD_SH-1:0] lowest_set(input logic [WORD_W-1:0] v);
    logic [WORD_SH-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = WORD_SH'(i);
      end
    end
    return idx;
  endfunction

endpackage

@@ rtl/bpa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bpa_ram
  import bpa_pkg::*;
#(
  parameter int WIDTH = WORD_W,
  parameter int DEPTH = WORD_W,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/bpa_front.sv @@
// Front end: accepts requests, classifies them and queues them for the engine.
module bpa_front
  import bpa_pkg::*;
#(
  parameter int MAX_PAGES = DEF_MAX_PAGES,
  localparam int LIM_W = $clog2(MAX_PAGES + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   operation,
  input  logic [PAGE_W-1:0] page_number,
  input  logic [LIM_W-1:0]  limit,
  input  logic              clearing,
  output bpa_entry_t        q_entry,
  output logic              q_valid,
  input  logic              q_pop
);

  localparam int QD = 2;

  bpa_entry_t slots [QD];
  bpa_entry_t entry_in;
  logic [1:0] cnt;
  logic [1:0] cnt_next;
  logic       wptr;
  logic       rptr;
  logic       push;
  logic       pop;

  always_comb begin
    entry_in.op   = op_t'(operation);
    entry_in.page = page_number;
    unique case (op_t'(operation)) inside
      OP_ALLOC: begin
        entry_in.kind = K_ALLOC;
      end
      OP_FREE, OP_REF, OP_UNREF, OP_QUERY, OP_RELEASE, OP_RESERVE: begin
        entry_in.kind = (32'(page_number) >= 32'(limit)) ? K_RANGE : K_PAGE;
      end
      default: begin
        entry_in.kind = K_IGNORE;
      end
    endcase
  end

  assign in_ready = (cnt != 2'(QD)) && !clearing;
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_entry  = slots[rptr];

  always_comb begin
    cnt_next = cnt;
    if (push && !pop) begin
      cnt_next = cnt + 2'd1;
    end else if (pop && !push) begin
      cnt_next = cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      wptr <= 1'b0;
      rptr <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= entry_in;
    end
  end

endmodule

@@ rtl/bpa_back.sv @@
// Back end: bitmap search, page state updates, reference counts and result register.
module bpa_back
  import bpa_pkg::*;
#(
  parameter int MAX_PAGES = DEF_MAX_PAGES,
  parameter int REF_MAX   = DEF_REF_MAX,
  localparam int LIM_W = $clog2(MAX_PAGES + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [LIM_W-1:0]    limit,
  input  bpa_entry_t          q_entry,
  input  logic                q_valid,
  output logic                q_pop,
  output logic                clearing,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [PAGE_W-1:0]   result_page,
  output logic [STATUS_W-1:0] status,
  output logic [REF_W-1:0]    ref_count,
  output logic [FREE_W-1:0]   free_count
);

  localparam int PW       = $clog2(MAX_PAGES);
  localparam int PIW      = (PW > SUM_SH + 1) ? PW : SUM_SH + 1;
  localparam int A0       = PIW - WORD_SH;
  localparam int A1       = PIW - SUM_SH;
  localparam int AR       = PIW - RC_SH;
  localparam int TOPN     = 1 << A1;
  localparam int FC_W     = LIM_W;
  localparam int RC_ROW_W = RC_LANES * REF_W;

  back_state_t state;
  back_state_t state_next;

  logic [AR-1:0]     clr_idx;
  logic [AR-1:0]     clr_idx_next;
  logic [TOPN-1:0]   top_bits;
  logic [TOPN-1:0]   top_bits_next;
  logic [FC_W-1:0]   free_cnt;
  logic [FC_W-1:0]   free_cnt_next;
  op_t               cur_op;
  op_t               cur_op_next;
  logic [PIW-1:0]    cur_page;
  logic [PIW-1:0]    cur_page_next;
  logic              has_free;
  logic              has_free_next;
  logic              out_valid_next;
  logic [PAGE_W-1:0] result_page_next;
  status_t           status_next;
  logic [REF_W-1:0]  ref_count_next;
  logic [FREE_W-1:0] free_count_next;

  logic                l0_we;
  logic [A0-1:0]       l0_waddr;
  logic [WORD_W-1:0]   l0_wdata;
  logic                l0_re;
  logic [A0-1:0]       l0_raddr;
  logic [WORD_W-1:0]   l0_rdata;
  logic                l1_we;
  logic [A1-1:0]       l1_waddr;
  logic [WORD_W-1:0]   l1_wdata;
  logic                l1_re;
  logic [A1-1:0]       l1_raddr;
  logic [WORD_W-1:0]   l1_rdata;
  logic                rc_we;
  logic [AR-1:0]       rc_waddr;
  logic [RC_ROW_W-1:0] rc_wdata;
  logic                rc_re;
  logic [AR-1:0]       rc_raddr;
  logic [RC_ROW_W-1:0] rc_rdata;

  logic                start;
  logic                top_any;
  logic [A1-1:0]       top_idx;
  logic [PIW-1:0]      ent_page;
  logic [WORD_SH-1:0]  l1_low;
  logic [PIW-1:0]      found_page;
  logic                found_oor;
  logic [WORD_SH-1:0]  bit_sel;
  logic [RC_SH-1:0]    lane;
  logic                page_used;
  logic [REF_W-1:0]    cnt;
  logic                u_new;
  logic [REF_W-1:0]    c_new;
  status_t             mod_status;
  logic [FC_W-1:0]     fc_new;
  logic [WORD_W-1:0]   new_word;
  logic [RC_ROW_W-1:0] new_row;
  logic [WORD_W-1:0]   new_l1;

  bpa_ram #(.WIDTH(WORD_W), .DEPTH(1 << A0)) u_l0_ram (
    .clk   (clk),
    .we    (l0_we),
    .waddr (l0_waddr),
    .wdata (l0_wdata),
    .re    (l0_re),
    .raddr (l0_raddr),
    .rdata (l0_rdata)
  );

  bpa_ram #(.WIDTH(WORD_W), .DEPTH(1 << A1)) u_l1_ram (
    .clk   (clk),
    .we    (l1_we),
    .waddr (l1_waddr),
    .wdata (l1_wdata),
    .re    (l1_re),
    .raddr (l1_raddr),
    .rdata (l1_rdata)
  );

  bpa_ram #(.WIDTH(RC_ROW_W), .DEPTH(1 << AR)) u_rc_ram (
    .clk   (clk),
    .we    (rc_we),
    .waddr (rc_waddr),
    .wdata (rc_wdata),
    .re    (rc_re),
    .raddr (rc_raddr),
    .rdata (rc_rdata)
  );

  assign start    = (state == BS_IDLE) && q_valid && (!out_valid || out_ready);
  assign top_any  = |top_bits;
  assign ent_page = PIW'(q_entry.page);

  always_comb begin
    top_idx = '0;
    for (int i = TOPN - 1; i >= 0; i--) begin
      if (top_bits[i]) begin
        top_idx = A1'(i);
      end
    end
  end

  assign l1_low     = lowest_set(l1_rdata);
  assign found_page = {cur_page[PIW-1:WORD_SH], lowest_set(~l0_rdata)};
  assign found_oor  = (32'(found_page) >= 32'(limit));
  assign bit_sel    = cur_page[WORD_SH-1:0];
  assign lane       = cur_page[RC_SH-1:0];
  assign page_used  = l0_rdata[bit_sel];
  assign cnt        = rc_rdata[int'(lane) * REF_W +: REF_W];

  // Per-page update of the used bit, the count and the free counter.
  always_comb begin
    u_new      = page_used;
    c_new      = cnt;
    mod_status = ST_DONE;
    fc_new     = free_cnt;
    unique case (cur_op) inside
      OP_ALLOC: begin
        u_new  = 1'b1;
        c_new  = REF_W'(1);
        fc_new = free_cnt - FC_W'(1);
      end
      OP_FREE, OP_RELEASE: begin
        if (page_used) begin
          u_new  = 1'b0;
          c_new  = '0;
          fc_new = free_cnt + FC_W'(1);
        end else begin
          mod_status = ST_NOCHANGE;
        end
      end
      OP_REF: begin
        if (cnt < REF_W'(REF_MAX)) begin
          c_new = cnt + REF_W'(1);
        end else begin
          mod_status = ST_NOCHANGE;
        end
      end
      OP_UNREF: begin
        if (cnt != '0) begin
          c_new = cnt - REF_W'(1);
          if ((cnt == REF_W'(1)) && page_used) begin
            u_new  = 1'b0;
            fc_new = free_cnt + FC_W'(1);
          end
        end else begin
          mod_status = ST_NOCHANGE;
        end
      end
      OP_RESERVE: begin
        if (!page_used) begin
          u_new  = 1'b1;
          fc_new = free_cnt - FC_W'(1);
        end else begin
          mod_status = ST_NOCHANGE;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    new_word                          = l0_rdata;
    new_word[bit_sel]                 = u_new;
    new_row                           = rc_rdata;
    new_row[int'(lane) * REF_W +: REF_W] = c_new;
    new_l1                            = l1_rdata;
    new_l1[cur_page[SUM_SH-1:WORD_SH]] = has_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BS_CLEAR: begin
        if (&clr_idx) begin
          state_next = BS_IDLE;
        end
      end
      BS_IDLE: begin
        if (start) begin
          if ((q_entry.kind == K_ALLOC) && top_any) begin
            state_next = BS_ALLOC_L1;
          end else if (q_entry.kind == K_PAGE) begin
            state_next = BS_MODIFY;
          end
        end
      end
      BS_ALLOC_L1: begin
        state_next = BS_ALLOC_L0;
      end
      BS_ALLOC_L0: begin
        state_next = found_oor ? BS_IDLE : BS_MODIFY;
      end
      BS_MODIFY: begin
        state_next = BS_SUMMARY;
      end
      BS_SUMMARY: begin
        state_next = BS_IDLE;
      end
      default: begin
        state_next = BS_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop            = 1'b0;
    clearing         = 1'b0;
    l0_we            = 1'b0;
    l0_waddr         = cur_page[PIW-1:WORD_SH];
    l0_wdata         = new_word;
    l0_re            = 1'b0;
    l0_raddr         = ent_page[PIW-1:WORD_SH];
    l1_we            = 1'b0;
    l1_waddr         = cur_page[PIW-1:SUM_SH];
    l1_wdata         = new_l1;
    l1_re            = 1'b0;
    l1_raddr         = cur_page[PIW-1:SUM_SH];
    rc_we            = 1'b0;
    rc_waddr         = cur_page[PIW-1:RC_SH];
    rc_wdata         = new_row;
    rc_re            = 1'b0;
    rc_raddr         = ent_page[PIW-1:RC_SH];
    clr_idx_next     = clr_idx;
    top_bits_next    = top_bits;
    free_cnt_next    = free_cnt;
    cur_op_next      = cur_op;
    cur_page_next    = cur_page;
    has_free_next    = has_free;
    out_valid_next   = out_valid && !out_ready;
    result_page_next = result_page;
    status_next      = status_t'(status);
    ref_count_next   = ref_count;
    free_count_next  = FREE_W'(free_cnt);
    unique case (state)
      BS_CLEAR: begin
        clearing     = 1'b1;
        rc_we        = 1'b1;
        rc_waddr     = clr_idx;
        rc_wdata     = '0;
        l0_we        = (clr_idx[AR-1:A0] == '0);
        l0_waddr     = clr_idx[A0-1:0];
        l0_wdata     = '1;
        l1_we        = (clr_idx[AR-1:A1] == '0);
        l1_waddr     = clr_idx[A1-1:0];
        l1_wdata     = '0;
        clr_idx_next = clr_idx + AR'(1);
      end
      BS_IDLE: begin
        if (start) begin
          q_pop = 1'b1;
          unique case (q_entry.kind)
            K_ALLOC: begin
              if (top_any) begin
                cur_op_next   = OP_ALLOC;
                cur_page_next = {top_idx, {SUM_SH{1'b0}}};
                l1_re         = 1'b1;
                l1_raddr      = top_idx;
              end else begin
                out_valid_next   = 1'b1;
                result_page_next = '0;
                status_next      = ST_OOM;
                ref_count_next   = '0;
              end
            end
            K_PAGE: begin
              cur_op_next   = q_entry.op;
              cur_page_next = ent_page;
              l0_re         = 1'b1;
              rc_re         = 1'b1;
            end
            K_RANGE: begin
              out_valid_next   = 1'b1;
              result_page_next = q_entry.page;
              status_next      = ST_RANGE;
              ref_count_next   = '0;
            end
            default: begin
              out_valid_next   = 1'b1;
              result_page_next = q_entry.page;
              status_next      = ST_NOCHANGE;
              ref_count_next   = '0;
            end
          endcase
        end
      end
      BS_ALLOC_L1: begin
        cur_page_next[SUM_SH-1:WORD_SH] = l1_low;
        l0_re    = 1'b1;
        l0_raddr = {cur_page[PIW-1:SUM_SH], l1_low};
      end
      BS_ALLOC_L0: begin
        if (found_oor) begin
          out_valid_next   = 1'b1;
          result_page_next = '0;
          status_next      = ST_OOM;
          ref_count_next   = '0;
        end else begin
          cur_page_next = found_page;
          rc_re         = 1'b1;
          rc_raddr      = found_page[PIW-1:RC_SH];
        end
      end
      BS_MODIFY: begin
        l0_we            = 1'b1;
        rc_we            = 1'b1;
        l1_re            = 1'b1;
        free_cnt_next    = fc_new;
        has_free_next    = ~&new_word;
        out_valid_next   = 1'b1;
        result_page_next = PAGE_W'(cur_page);
        status_next      = mod_status;
        ref_count_next   = c_new;
        free_count_next  = FREE_W'(fc_new);
      end
      BS_SUMMARY: begin
        l1_we = 1'b1;
        top_bits_next[cur_page[PIW-1:SUM_SH]] = |new_l1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BS_CLEAR;
      clr_idx   <= '0;
      top_bits  <= '0;
      free_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_idx   <= clr_idx_next;
      top_bits  <= top_bits_next;
      free_cnt  <= free_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_op      <= cur_op_next;
    cur_page    <= cur_page_next;
    has_free    <= has_free_next;
    result_page <= result_page_next;
    status      <= status_next;
    ref_count   <= ref_count_next;
    free_count  <= free_count_next;
  end

endmodule

@@ rtl/bitmap_page_allocator_refcount.sv @@
// Top level of the physical page frame allocator with per-page reference counts.
//
// Each request produces exactly one response, in request order. Requests are
// queued two deep ahead of the engine. The engine answers an ignored operation
// code, an out-of-range page or an allocation when no page is free at all
// straight from its idle state. Free, ref, unref, query, release and reserve
// make one read, modify and write pass over the used bitmap and the count
// memory, then a summary update. An allocation walks a three-level structure:
// a register of non-empty summary words, a summary memory of non-full bitmap
// words, and the bitmap itself; if its only free pages lie at or above the
// active count it ends after the bitmap read, else it goes on through the
// modify and summary steps. After reset the block sweeps its memories, one row
// per cycle, and takes no request until the sweep is done; the active_pages
// register may be written at any time it is idle.
module bitmap_page_allocator_refcount
  import bpa_pkg::*;
#(
  parameter int MAX_PAGES = DEF_MAX_PAGES,
  parameter int REF_MAX   = DEF_REF_MAX
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [FREE_W-1:0]   cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     operation,
  input  logic [PAGE_W-1:0]   page_number,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [PAGE_W-1:0]   result_page,
  output logic [STATUS_W-1:0] status,
  output logic [REF_W-1:0]    ref_count,
  output logic [FREE_W-1:0]   free_count
);

  localparam int LIM_W = $clog2(MAX_PAGES + 1);

  logic [FREE_W-1:0] active_pages;
  logic [LIM_W-1:0]  limit;
  bpa_entry_t        q_entry;
  logic              q_valid;
  logic              q_pop;
  logic              clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_pages <= ACTIVE_RESET;
    end else if (cfg_we) begin
      active_pages <= cfg_data;
    end
  end

  // Page numbers at or above the clamped active count are out of range.
  assign limit = (32'(active_pages) > 32'(MAX_PAGES)) ? LIM_W'(MAX_PAGES)
                                                      : LIM_W'(active_pages);

  bpa_front #(.MAX_PAGES(MAX_PAGES)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .page_number (page_number),
    .limit       (limit),
    .clearing    (clearing),
    .q_entry     (q_entry),
    .q_valid     (q_valid),
    .q_pop       (q_pop)
  );

  bpa_back #(.MAX_PAGES(MAX_PAGES), .REF_MAX(REF_MAX)) u_back (
    .clk         (clk),
    .rst         (rst),
    .limit       (limit),
    .q_entry     (q_entry),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .clearing    (clearing),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_page (result_page),
    .status      (status),
    .ref_count   (ref_count),
    .free_count  (free_count)
  );

endmodule

@@ sim/tb_bitmap_page_allocator_refcount.sv @@
// Self-checking testbench for the page frame allocator with reference counts.
`timescale 1ns / 1ps

module tb_bitmap_page_allocator_refcount
  import bpa_pkg::*;
();

  localparam int PAGE_SPAN      = DEF_MAX_PAGES;
  localparam int REF_LIMIT      = DEF_REF_MAX;
  localparam int WATCHDOG_LIMIT = 100000;
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [PAGE_W-1:0] page;
  } page_request_t;

  typedef struct {
    logic [PAGE_W-1:0] page;
    status_t           status;
    logic [REF_W-1:0]  refs;
    logic [FREE_W-1:0] free_left;
  } page_reply_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [FREE_W-1:0]   cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     operation = '0;
  logic [PAGE_W-1:0]   page_number = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [PAGE_W-1:0]   result_page;
  logic [STATUS_W-1:0] status;
  logic [REF_W-1:0]    ref_count;
  logic [FREE_W-1:0]   free_count;

  bit                page_used [PAGE_SPAN];
  logic [REF_W-1:0]  page_refs [PAGE_SPAN];
  bit                free_pool [int];
  int                free_total;
  logic [FREE_W-1:0] active_setting;

  page_request_t pending_requests[$];
  page_reply_t   expected_replies[$];
  int            error_count = 0;
  int            reply_index = 0;
  int            idle_cycles = 0;
  int            send_gap = 0;
  int            stall_left = 0;
  bit            calm = 1'b0;

  int phase_setting [7] = '{64, 0, 1, 262143, 131071, 17, 131072};
  int phase_items   [7] = '{110, 25, 35, 90, 50, 50, 40};

  bitmap_page_allocator_refcount uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .page_number(page_number),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_page(result_page),
    .status     (status),
    .ref_count  (ref_count),
    .free_count (free_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (error_count < 100) begin
      $display("Mismatch on reply %0d, %s: got %0d, expected %0d", reply_index, what, got,
               want);
    end
    error_count++;
  endtask

  function automatic void return_to_pool(input int page);
    if (page_used[page]) begin
      page_used[page] = 1'b0;
      free_pool[page] = 1'b1;
      free_total++;
    end
  endfunction

  function automatic void apply_page_op(input logic [OP_W-1:0] op,
                                        input logic [PAGE_W-1:0] page);
    page_reply_t reply;
    int          limit;
    int          lowest;
    limit = (active_setting > PAGE_SPAN) ? PAGE_SPAN : int'(active_setting);
    reply.page   = page;
    reply.status = ST_DONE;
    reply.refs   = '0;
    if (op == OP_ALLOC) begin
      reply.page   = '0;
      reply.status = ST_OOM;
      if (free_pool.first(lowest) && lowest < limit) begin
        free_pool.delete(lowest);
        page_used[lowest] = 1'b1;
        page_refs[lowest] = 8'd1;
        free_total--;
        reply.page   = PAGE_W'(lowest);
        reply.refs   = 8'd1;
        reply.status = ST_DONE;
      end
    end else if (op == OP_UNUSED) begin
      reply.status = ST_NOCHANGE;
    end else if (int'(page) >= limit) begin
      reply.status = ST_RANGE;
    end else begin
      case (op)
        OP_FREE, OP_RELEASE: begin
          if (page_used[page]) begin
            return_to_pool(page);
            page_refs[page] = '0;
          end else begin
            reply.status = ST_NOCHANGE;
          end
        end
        OP_REF: begin
          if (page_refs[page] < REF_LIMIT) begin
            page_refs[page] = page_refs[page] + 8'd1;
          end else begin
            reply.status = ST_NOCHANGE;
          end
        end
        OP_UNREF: begin
          if (page_refs[page] != 0) begin
            page_refs[page] = page_refs[page] - 8'd1;
            if (page_refs[page] == 0) begin
              return_to_pool(page);
            end
          end else begin
            reply.status = ST_NOCHANGE;
          end
        end
        OP_RESERVE: begin
          if (!page_used[page]) begin
            page_used[page] = 1'b1;
            free_pool.delete(page);
            free_total--;
          end else begin
            reply.status = ST_NOCHANGE;
          end
        end
        default: begin
        end
      endcase
      reply.refs = page_refs[page];
    end
    reply.free_left = FREE_W'(free_total);
    expected_replies.push_back(reply);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        apply_page_op(operation, page_number);
      end
      if (in_valid && !in_ready) begin
      end else if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        in_valid <= 1'b0;
        send_gap <= $urandom_range(0, 13);
      end else if (pending_requests.size() != 0) begin
        in_valid    <= 1'b1;
        operation   <= pending_requests[0].op;
        page_number <= pending_requests[0].page;
        void'(pending_requests.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    page_reply_t want;
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("reply with no transaction pending", result_page, 0);
        end else begin
          want = expected_replies.pop_front();
          if (result_page !== want.page) report_mismatch("result_page", result_page, want.page);
          if (status !== want.status) report_mismatch("status", status, want.status);
          if (ref_count !== want.refs) report_mismatch("ref_count", ref_count, want.refs);
          if (free_count !== want.free_left) begin
            report_mismatch("free_count", free_count, want.free_left);
          end
        end
        reply_index++;
      end
      if (stall_left != 0) begin
        out_ready  <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        out_ready  <= 1'b0;
        stall_left <= $urandom_range(0, 13);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", idle_cycles);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_request(input logic [OP_W-1:0] op, input int page);
    page_request_t req;
    req.op   = op;
    req.page = PAGE_W'(page);
    pending_requests.push_back(req);
  endtask

  task automatic wait_until_drained();
    while (pending_requests.size() != 0 || in_valid || expected_replies.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic set_active_pages(input int value);
    wait_until_drained();
    repeat (8) @(posedge clk);
    cfg_we         <= 1'b1;
    cfg_data       <= FREE_W'(value);
    active_setting = FREE_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [OP_W-1:0] pick_operation();
    int w;
    w = $urandom_range(0, 99);
    if (w < 20) return OP_RELEASE;
    if (w < 38) return OP_ALLOC;
    if (w < 53) return OP_REF;
    if (w < 68) return OP_UNREF;
    if (w < 78) return OP_FREE;
    if (w < 86) return OP_QUERY;
    if (w < 95) return OP_RESERVE;
    return OP_UNUSED;
  endfunction

  function automatic int pick_page(input int limit);
    int w;
    int p;
    w = $urandom_range(0, 99);
    if (w < 75) begin
      p = $urandom_range(0, 47);
    end else if (w < 87) begin
      p = limit - 1 + $urandom_range(0, 2);
      if (p < 0) p = 0;
      if (p > PAGE_SPAN - 1) p = PAGE_SPAN - 1;
    end else begin
      p = $urandom_range(0, PAGE_SPAN - 1);
    end
    return p;
  endfunction

  initial begin
    int limit;
    for (int i = 0; i < PAGE_SPAN; i++) begin
      page_used[i] = 1'b1;
      page_refs[i] = '0;
    end
    free_total     = 0;
    active_setting = ACTIVE_RESET;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (!in_ready) @(negedge clk);

    set_active_pages(PAGE_SPAN);
    queue_request(OP_ALLOC, 0);
    queue_request(OP_QUERY, 0);
    queue_request(OP_RELEASE, 0);
    queue_request(OP_RELEASE, 0);
    queue_request(OP_RELEASE, PAGE_SPAN - 1);
    queue_request(OP_ALLOC, 77);
    queue_request(OP_REF, 0);
    queue_request(OP_UNREF, 0);
    queue_request(OP_UNREF, 0);
    queue_request(OP_UNREF, 0);
    queue_request(OP_FREE, 0);
    queue_request(OP_REF, 0);
    queue_request(OP_UNREF, 0);
    queue_request(OP_RESERVE, 0);
    queue_request(OP_RESERVE, 0);
    queue_request(OP_FREE, 0);
    queue_request(OP_ALLOC, 0);
    queue_request(OP_ALLOC, PAGE_SPAN - 1);
    queue_request(OP_ALLOC, 0);
    queue_request(OP_FREE, PAGE_SPAN - 1);
    queue_request(OP_UNUSED, PAGE_SPAN - 1);
    queue_request(OP_UNUSED, 0);
    queue_request(OP_QUERY, PAGE_SPAN - 1);
    for (int i = 0; i < 258; i++) begin
      queue_request(OP_REF, 9);
    end
    queue_request(OP_QUERY, 9);

    for (int ph = 0; ph < 7; ph++) begin
      set_active_pages(phase_setting[ph]);
      if (ph == 6) calm = 1'b1;
      limit = (phase_setting[ph] > PAGE_SPAN) ? PAGE_SPAN : phase_setting[ph];
      for (int i = 0; i < phase_items[ph]; i++) begin
        queue_request(pick_operation(), pick_page(limit));
      end
    end

    wait_until_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
